// ===== sv/smdu_pkg.sv =====
// Shared types and constants of the serial multiply and divide unit.
package smdu_pkg;

    localparam int CNT_W          = 5;
    localparam int FIELD_W        = 16;
    localparam int SHIFT_W        = 32;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int S_TDATA_W      = 80;
    localparam int S_TUSER_W      = 1;
    localparam int M_TDATA_W      = 40;

    typedef enum logic {
        REQ_STEP = 1'b0,
        REQ_LOAD = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t           req_type;
        logic [SHIFT_W-1:0]  shifter;
        logic [FIELD_W-1:0]  prod_rem;
        logic [FIELD_W-1:0]  quot_mult;
        logic [CNT_W-1:0]    div_count;
        logic [CNT_W-1:0]    mul_count;
    } req_t;

    typedef struct packed {
        logic                busy;
        logic [FIELD_W-1:0]  prod_rem;
        logic [FIELD_W-1:0]  quot_mult;
    } res_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } in_stage_t;

endpackage

// ===== sv/smdu_in_stage.sv =====
// Input register stage: captures one request beat and unpacks its fields.
module smdu_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [smdu_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [smdu_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                        take,
    output smdu_pkg::in_stage_t         stage
);
    import smdu_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    req_t req_in;

    always_comb begin
        req_in.mul_count = s_tdata[4:0];
        req_in.div_count = s_tdata[9:5];
        req_in.quot_mult = s_tdata[25:10];
        req_in.prod_rem  = s_tdata[41:26];
        req_in.shifter   = s_tdata[73:42];
        req_in.req_type  = req_kind_t'(s_tuser[0]);
    end

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= req_in;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.req   = req_reg;

endmodule

// ===== sv/smdu_step.sv =====
// Datapath of one item: load, or one multiply step followed by one divide step.
module smdu_step #(
    parameter int DATA_WIDTH = smdu_pkg::DATA_WIDTH_DEF
) (
    input  smdu_pkg::req_t                 req,
    input  logic [smdu_pkg::CNT_W-1:0]     mul_cnt,
    input  logic [smdu_pkg::CNT_W-1:0]     div_cnt,
    input  logic [DATA_WIDTH-1:0]          qm,
    input  logic [DATA_WIDTH-1:0]          pr,
    input  logic [smdu_pkg::SHIFT_W-1:0]   sh,
    output logic [smdu_pkg::CNT_W-1:0]     mul_cnt_next,
    output logic [smdu_pkg::CNT_W-1:0]     div_cnt_next,
    output logic [DATA_WIDTH-1:0]          qm_next,
    output logic [DATA_WIDTH-1:0]          pr_next,
    output logic [smdu_pkg::SHIFT_W-1:0]   sh_next,
    output smdu_pkg::res_t                 res
);
    import smdu_pkg::*;

    logic                  mul_act;
    logic                  div_act;
    logic [CNT_W-1:0]      m_cnt;
    logic [DATA_WIDTH-1:0] m_qm;
    logic [DATA_WIDTH-1:0] m_pr;
    logic [SHIFT_W-1:0]    m_sh;
    logic [SHIFT_W-1:0]    d_sh;
    logic                  ge;
    logic [CNT_W-1:0]      d_cnt;
    logic [DATA_WIDTH-1:0] d_qm;
    logic [DATA_WIDTH-1:0] d_pr;

    function automatic logic [SHIFT_W-1:0] m_sh_shift(input logic [SHIFT_W-1:0] v);
        m_sh_shift = {v[SHIFT_W-2:0], 1'b0};
    endfunction

    always_comb begin
        mul_act = (mul_cnt != '0);
        m_cnt   = mul_act ? mul_cnt - CNT_W'(1) : mul_cnt;
        m_pr    = (mul_act && qm[0]) ? pr + sh[DATA_WIDTH-1:0] : pr;
        m_qm    = mul_act ? (qm >> 1) : qm;
        m_sh    = mul_act ? (m_sh_shift(sh)) : sh;

        div_act = (div_cnt != '0);
        d_cnt   = div_act ? div_cnt - CNT_W'(1) : div_cnt;
        d_sh    = div_act ? (m_sh >> 1) : m_sh;
        ge      = (SHIFT_W'(m_pr) >= d_sh);
        d_qm    = div_act ? {m_qm[DATA_WIDTH-2:0], ge} : m_qm;
        d_pr    = (div_act && ge) ? m_pr - d_sh[DATA_WIDTH-1:0] : m_pr;
    end

    always_comb begin
        case (req.req_type)
            REQ_LOAD: begin
                mul_cnt_next = req.mul_count;
                div_cnt_next = req.div_count;
                qm_next      = DATA_WIDTH'(req.quot_mult);
                pr_next      = DATA_WIDTH'(req.prod_rem);
                sh_next      = req.shifter;
            end
            default: begin
                mul_cnt_next = m_cnt;
                div_cnt_next = d_cnt;
                qm_next      = d_qm;
                pr_next      = d_pr;
                sh_next      = d_sh;
            end
        endcase
    end

    assign res.quot_mult = FIELD_W'(qm_next);
    assign res.prod_rem  = FIELD_W'(pr_next);
    assign res.busy      = (mul_cnt_next != '0) || (div_cnt_next != '0);

endmodule

// ===== sv/smdu_core.sv =====
// Unit state and result register, advanced together as each item retires.
module smdu_core #(
    parameter int DATA_WIDTH = smdu_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  smdu_pkg::in_stage_t            stage,
    output logic                           take,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [smdu_pkg::M_TDATA_W-1:0] m_tdata
);
    import smdu_pkg::*;

    logic [CNT_W-1:0]      mul_cnt_reg;
    logic [CNT_W-1:0]      div_cnt_reg;
    logic [DATA_WIDTH-1:0] qm_reg;
    logic [DATA_WIDTH-1:0] pr_reg;
    logic [SHIFT_W-1:0]    sh_reg;
    logic [CNT_W-1:0]      mul_cnt_next;
    logic [CNT_W-1:0]      div_cnt_next;
    logic [DATA_WIDTH-1:0] qm_next;
    logic [DATA_WIDTH-1:0] pr_next;
    logic [SHIFT_W-1:0]    sh_next;
    res_t                  res_next;
    res_t                  res_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    smdu_step #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_step (
        .req          (stage.req),
        .mul_cnt      (mul_cnt_reg),
        .div_cnt      (div_cnt_reg),
        .qm           (qm_reg),
        .pr           (pr_reg),
        .sh           (sh_reg),
        .mul_cnt_next (mul_cnt_next),
        .div_cnt_next (div_cnt_next),
        .qm_next      (qm_next),
        .pr_next      (pr_next),
        .sh_next      (sh_next),
        .res          (res_next)
    );

    assign take = stage.valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            mul_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            qm_reg        <= '0;
            pr_reg        <= '0;
            sh_reg        <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                mul_cnt_reg <= mul_cnt_next;
                div_cnt_reg <= div_cnt_next;
                qm_reg      <= qm_next;
                pr_reg      <= pr_next;
                sh_reg      <= sh_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(res_t)){1'b0}}, res_reg};

endmodule

// ===== sv/serial_multiply_divide_unit_top.sv =====
// Top level of the serial multiply and divide unit.
//
//  channel  dir  tdata (low bit up)                                     tuser
//  s_       in   mul_count, div_count, quot_mult, prod_rem, shifter     req_type
//  m_       out  quot_mult_out, prod_rem_out, busy_res                  -
//
// One item per cycle unless the result stalls; input then result register.
// The whole step (load mux, one multiply add, one divide compare and subtract)
// sits between the input register and the state/result registers.
// Reset clears both stage valids and all unit state to zero.
// A stalled result holds its stage; an empty input stage takes one more beat.
module serial_multiply_divide_unit_top #(
    parameter int DATA_WIDTH = smdu_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mul_count[4:0], div_count[9:5], quot_mult[25:10], prod_rem[41:26],
    // shifter[73:42], zero pad
    input  logic [smdu_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic [smdu_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // quot_mult_out[15:0], prod_rem_out[31:16], busy_res[32], zero pad
    output logic [smdu_pkg::M_TDATA_W-1:0] m_tdata
);
    import smdu_pkg::*;

    in_stage_t stage;
    logic      take;

    smdu_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .take     (take),
        .stage    (stage)
    );

    smdu_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stage    (stage),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/smdu_checker.sv =====
// Port-level checks of the serial multiply and divide unit, bound to the top.
module smdu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [smdu_pkg::M_TDATA_W-1:0] m_tdata
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("stages not empty after reset");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted beat produced no result in time");

endmodule

bind serial_multiply_divide_unit_top smdu_checker u_smdu_checker (.*);
